[hdl/mpte_pkg.sv]
// Shared definitions for the memory pattern test engine.
// Phase, operation and register codes, pattern constants, item field layout.
// No dependencies.
`default_nettype none

package mpte_pkg;

  // item widths: fields packed from bit 0, padded to whole bytes
  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 104;

  // output item field positions
  localparam int unsigned OUT_OP_LSB    = 0;
  localparam int unsigned OUT_ADDR_LSB  = 2;
  localparam int unsigned OUT_WDATA_LSB = 34;
  localparam int unsigned OUT_BUSY_BIT  = 66;
  localparam int unsigned OUT_DONE_BIT  = 67;
  localparam int unsigned OUT_PASS_BIT  = 68;
  localparam int unsigned OUT_FAIL_LSB  = 69;

  // test phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WRITE    = 3'd1;
  localparam logic [2:0] PH_CHECK    = 3'd2;
  localparam logic [2:0] PH_INVCHECK = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;

  // memory operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN_MODE  = 3'd0;
  localparam logic [2:0] REG_WITH_INVERSE  = 3'd1;
  localparam logic [2:0] REG_BASE_ADDRESS  = 3'd2;
  localparam logic [2:0] REG_LIMIT_ADDRESS = 3'd3;
  localparam logic [2:0] REG_RANDOM_SEED   = 3'd4;

  // configuration reset values
  localparam logic [31:0] BASE_RESET  = 32'h6000_0000;
  localparam logic [31:0] LIMIT_RESET = 32'h8000_0000;
  localparam logic [31:0] SEED_RESET  = 32'h00FF_FF00;

  // pattern and address constants
  localparam logic [31:0] MWC_MULT   = 32'hFFFF_DA61;
  localparam logic [31:0] TOP_BIT    = 32'h8000_0000;
  localparam logic [31:0] WORD_STEP  = 32'd4;
  localparam logic [31:0] ADDR_LAST  = 32'hFFFF_FFFB;
  localparam logic [31:0] ADDR_SAT   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic update;   // commit the step
    logic restart;  // reload from seed or one
    logic advance;  // step the generator after use
    logic mode;     // 0 walking one, 1 multiply-with-carry
  } pat_ctrl_t;

endpackage

`default_nettype wire

[hdl/mpte_pattern.sv]
// Pattern generator: walking one or 32-bit multiply-with-carry sequence.
// Depends on mpte_pkg.
`default_nettype none

module mpte_pattern (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mpte_pkg::pat_ctrl_t ctrl,
  input  wire logic [31:0]        seed,
  output logic [31:0]             pattern
);

  logic [31:0] low;
  logic [31:0] carry;
  logic [31:0] low_next;
  logic [31:0] carry_next;
  logic [31:0] cur_carry;
  logic [63:0] mwc;

  always_comb begin
    pattern   = ctrl.restart ? (ctrl.mode ? seed : 32'd1) : low;
    cur_carry = ctrl.restart ? 32'd0 : carry;
    mwc       = 64'(mpte_pkg::MWC_MULT) * 64'(pattern) + 64'(cur_carry);
    low_next   = pattern;
    carry_next = cur_carry;
    if (ctrl.advance) begin
      if (ctrl.mode) begin
        low_next   = mwc[31:0];
        carry_next = mwc[63:32];
      end else if (pattern == mpte_pkg::TOP_BIT || pattern == 32'd0) begin
        low_next = 32'd1;
      end else begin
        low_next = {pattern[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low   <= '0;
      carry <= '0;
    end else if (ctrl.update) begin
      low   <= low_next;
      carry <= carry_next;
    end
  end

endmodule

`default_nettype wire

[hdl/memory_pattern_test_engine.sv]
// Memory pattern test engine top level: stream channels, run control, compare.
// Depends on mpte_pkg and mpte_pattern.
//
// Each input item (start_req, read_data) yields exactly one result item that
// carries at most one memory access (mem_op, mem_address, write_data) and the
// run status (busy_res, done_res, passed, fail_address). A start_req item
// starts a run at base_address: pass one writes the pattern, pass two reads
// and compares (and rewrites inverted with with_inverse), pass three checks
// the inverted words. The data for a read belongs in read_data of the next
// input item. The first mismatch ends the run with its address.
// Throughput: one item per cycle unless the receiver stalls, set by the
// combinational step (address compare, pattern multiply) between the input and
// output registers. s_tready stays high while the output register is empty or
// being taken; when the receiver stalls, one item waits in the input register
// and then s_tready drops. Configuration writes go through cfg_write,
// cfg_index and cfg_data; the user must make them only while no run is active,
// as the block does not enforce it. Reset clears both registers, returns the
// configuration to its defaults and the engine to idle.
`default_nettype none

module memory_pattern_test_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // start_req[0], read_data[32:1], zero pad [39:33]
  input  wire logic [mpte_pkg::IN_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // mem_op[1:0], mem_address[33:2], write_data[65:34], busy_res[66],
  // done_res[67], passed[68], fail_address[100:69], zero pad [103:101]
  output logic [mpte_pkg::OUT_W-1:0]      m_tdata,
  input  wire logic                       cfg_write,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [31:0]                cfg_data
);

  // configuration
  logic        pattern_mode;
  logic        with_inverse;
  logic [31:0] base_address;
  logic [31:0] limit_address;
  logic [31:0] random_seed;

  // input register
  logic        in_valid;
  logic        in_start;
  logic [31:0] in_rdata;
  logic        fire;

  // run state
  logic [2:0]  phase;
  logic [31:0] word_address;
  logic        read_pending;
  logic [31:0] expected_word;
  logic [31:0] pending_address;
  logic [31:0] failed_at;
  logic        pass_flag;

  logic [2:0]  phase_next;
  logic [31:0] word_address_next;
  logic        read_pending_next;
  logic [31:0] expected_word_next;
  logic [31:0] pending_address_next;
  logic [31:0] failed_at_next;
  logic        pass_flag_next;

  logic [1:0]  op;
  logic [31:0] addr;
  logic [31:0] wdata;
  logic        issue;
  logic        empty_range;
  logic        active;
  logic [31:0] pattern;
  logic [mpte_pkg::OUT_W-1:0] result;

  mpte_pkg::pat_ctrl_t pat_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode  <= 1'b0;
      with_inverse  <= 1'b0;
      base_address  <= mpte_pkg::BASE_RESET;
      limit_address <= mpte_pkg::LIMIT_RESET;
      random_seed   <= mpte_pkg::SEED_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mpte_pkg::REG_PATTERN_MODE:  pattern_mode  <= cfg_data[0];
        mpte_pkg::REG_WITH_INVERSE:  with_inverse  <= cfg_data[0];
        mpte_pkg::REG_BASE_ADDRESS:  base_address  <= cfg_data;
        mpte_pkg::REG_LIMIT_ADDRESS: limit_address <= cfg_data;
        mpte_pkg::REG_RANDOM_SEED:   random_seed   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_start <= s_tdata[0];
      in_rdata <= s_tdata[32:1];
    end
  end

  mpte_pattern u_pattern (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (pat_ctrl),
    .seed    (random_seed),
    .pattern (pattern)
  );

  assign empty_range = base_address >= limit_address;

  always_comb begin
    phase_next           = phase;
    word_address_next    = word_address;
    read_pending_next    = read_pending;
    expected_word_next   = expected_word;
    pending_address_next = pending_address;
    failed_at_next       = failed_at;
    pass_flag_next       = pass_flag;
    op                   = mpte_pkg::OP_NONE;
    addr                 = 32'd0;
    wdata                = 32'd0;
    issue                = 1'b1;
    pat_ctrl.update      = fire;
    pat_ctrl.restart     = 1'b0;
    pat_ctrl.advance     = 1'b0;
    pat_ctrl.mode        = pattern_mode;

    if (in_start) begin
      phase_next        = mpte_pkg::PH_WRITE;
      word_address_next = base_address;
      pat_ctrl.restart  = 1'b1;
      read_pending_next = 1'b0;
      pass_flag_next    = 1'b0;
      failed_at_next    = 32'd0;
    end else if (read_pending) begin
      read_pending_next = 1'b0;
      if (in_rdata != expected_word) begin
        failed_at_next = pending_address;
        pass_flag_next = 1'b0;
        phase_next     = mpte_pkg::PH_DONE;
        issue          = 1'b0;
      end else if (phase == mpte_pkg::PH_CHECK && with_inverse) begin
        op    = mpte_pkg::OP_WRITE;
        addr  = pending_address;
        wdata = ~expected_word;
        issue = 1'b0;
      end
    end

    // end of pass: move on, skipping passes over an empty range
    if (issue && (phase_next == mpte_pkg::PH_WRITE || phase_next == mpte_pkg::PH_CHECK ||
                  phase_next == mpte_pkg::PH_INVCHECK) &&
        word_address_next >= limit_address) begin
      case (phase_next)
        mpte_pkg::PH_WRITE:
          phase_next = empty_range ? mpte_pkg::PH_DONE : mpte_pkg::PH_CHECK;
        mpte_pkg::PH_CHECK:
          phase_next = (with_inverse && !empty_range) ? mpte_pkg::PH_INVCHECK
                                                      : mpte_pkg::PH_DONE;
        default:
          phase_next = mpte_pkg::PH_DONE;
      endcase
      word_address_next = base_address;
      if (phase_next == mpte_pkg::PH_DONE) begin
        pass_flag_next = 1'b1;
      end else begin
        pat_ctrl.restart = 1'b1;
      end
    end

    if (issue && (phase_next == mpte_pkg::PH_WRITE || phase_next == mpte_pkg::PH_CHECK ||
                  phase_next == mpte_pkg::PH_INVCHECK)) begin
      addr = word_address_next;
      if (phase_next == mpte_pkg::PH_WRITE) begin
        op    = mpte_pkg::OP_WRITE;
        wdata = pattern;
      end else begin
        op                   = mpte_pkg::OP_READ;
        expected_word_next   = (phase_next == mpte_pkg::PH_CHECK) ? pattern : ~pattern;
        pending_address_next = word_address_next;
        read_pending_next    = 1'b1;
      end
      pat_ctrl.advance  = 1'b1;
      word_address_next = (word_address_next > mpte_pkg::ADDR_LAST) ? mpte_pkg::ADDR_SAT
                                                                    : word_address_next +
                                                                      mpte_pkg::WORD_STEP;
    end

    active = phase_next == mpte_pkg::PH_WRITE || phase_next == mpte_pkg::PH_CHECK ||
             phase_next == mpte_pkg::PH_INVCHECK;
    result = {3'b000, failed_at_next, pass_flag_next,
              phase_next == mpte_pkg::PH_DONE, active, wdata, addr, op};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mpte_pkg::PH_IDLE;
      word_address    <= '0;
      read_pending    <= 1'b0;
      expected_word   <= '0;
      pending_address <= '0;
      failed_at       <= '0;
      pass_flag       <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      word_address    <= word_address_next;
      read_pending    <= read_pending_next;
      expected_word   <= expected_word_next;
      pending_address <= pending_address_next;
      failed_at       <= failed_at_next;
      pass_flag       <= pass_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= result;
    end
  end

endmodule

`default_nettype wire

[hdl/mpte_checker.sv]
// Port-level checks for the memory pattern test engine, bound to the top level.
// Depends on mpte_pkg.
`default_nettype none

module mpte_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [mpte_pkg::OUT_W-1:0] m_tdata
);

  logic [1:0]  op;
  logic [31:0] addr;
  logic [31:0] wdata;
  logic        busy;
  logic        done;
  logic        pass;

  assign op    = m_tdata[mpte_pkg::OUT_OP_LSB +: 2];
  assign addr  = m_tdata[mpte_pkg::OUT_ADDR_LSB +: 32];
  assign wdata = m_tdata[mpte_pkg::OUT_WDATA_LSB +: 32];
  assign busy  = m_tdata[mpte_pkg::OUT_BUSY_BIT];
  assign done  = m_tdata[mpte_pkg::OUT_DONE_BIT];
  assign pass  = m_tdata[mpte_pkg::OUT_PASS_BIT];

  a_op_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (op == mpte_pkg::OP_NONE || op == mpte_pkg::OP_WRITE ||
                  op == mpte_pkg::OP_READ))
    else $error("mem_op out of range");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(busy && done))
    else $error("busy and done both set");

  a_pass_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && pass) |-> (done && !busy))
    else $error("passed without finished run");

  a_idle_access: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && op != mpte_pkg::OP_WRITE) |-> (wdata == 32'd0 &&
      (op != mpte_pkg::OP_NONE || addr == 32'd0)))
    else $error("stray address or data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled item changed");

endmodule

bind memory_pattern_test_engine mpte_checker u_mpte_checker (.*);

`default_nettype wire
